[hdl/smgr_pkg.sv]
// smgr_pkg: codes, field widths and shared structs of the stub matching graph randomizer
// depends on nothing; used by smgr_ctrl, smgr_dpath and the top module
package smgr_pkg;

    localparam int VERTEX_W = 8;
    localparam int PICK_W   = 11;
    localparam int LEFT_W   = 11;
    localparam int RATIO_W  = 11;
    localparam int FAIL_W   = 22;

    localparam logic [RATIO_W-1:0] RATIO_RESET = 11'd100;
    localparam logic [FAIL_W-1:0]  FAIL_MAX    = {FAIL_W{1'b1}};

    typedef enum logic [1:0] {
        MODE_LOAD_SINGLE = 2'd0,
        MODE_LOAD_DOUBLE = 2'd1,
        MODE_DRAW        = 2'd2,
        MODE_RESTART     = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_LOADED       = 3'd0,
        ST_PLACED       = 3'd1,
        ST_CONFLICT     = 3'd2,
        ST_GAVE_UP      = 3'd3,
        ST_BAD_PICK     = 3'd4,
        ST_NOTHING_LEFT = 3'd5
    } status_t;

    typedef struct packed {
        mode_t               mode;
        logic [VERTEX_W-1:0] src_vertex;
        logic [VERTEX_W-1:0] dst_vertex;
        logic [PICK_W-1:0]   out_pick;
        logic [PICK_W-1:0]   in_pick;
    } request_t;

    typedef struct packed {
        status_t             status;
        logic [VERTEX_W-1:0] edge_src;
        logic [VERTEX_W-1:0] edge_dst;
        logic                edge_is_double;
        logic [LEFT_W-1:0]   single_left;
        logic [LEFT_W-1:0]   double_left;
    } result_t;

    typedef struct packed {
        logic in_ready;
        logic clear_en;
        logic pick_rd;
        logic last_rd;
        logic rowt_rd;
        logic check;
        logic wrt;
        logic push;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic draw_go;
        logic restart;
        logic place_dbl;
        logic clear_last;
        logic out_free;
    } dp_status_t;

endpackage

[hdl/smgr_stream_if.sv]
// smgr_stream_if: valid/ready channel carrying one item of payload type T
// depends on nothing; instantiated with smgr_pkg payload structs
interface smgr_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/smgr_ram.sv]
// smgr_ram: generic single write port, single read port ram with registered read
// depends on nothing
module smgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/smgr_ctrl.sv]
// smgr_ctrl: sequencing state machine of the randomizer
// depends on smgr_pkg; drives commands to smgr_dpath and reads its status
module smgr_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  smgr_pkg::dp_status_t  stat,
    output smgr_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_PICK  = 8'b0000_0100,
        S_LAST  = 8'b0000_1000,
        S_ROWT  = 8'b0001_0000,
        S_CHECK = 8'b0010_0000,
        S_WRT   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   clr_pend_reg;
    logic   clr_pend_next;

    always_comb
    begin
        cmd           = '0;
        state_next    = state_reg;
        clr_pend_next = clr_pend_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (stat.in_valid)
                begin
                    if (stat.draw_go)
                    begin
                        state_next = S_PICK;
                    end
                    else
                    begin
                        state_next    = S_DONE;
                        clr_pend_next = stat.restart;
                    end
                end
            end
            S_PICK:
            begin
                cmd.pick_rd = 1'b1;
                state_next  = S_LAST;
            end
            S_LAST:
            begin
                cmd.last_rd = 1'b1;
                state_next  = S_ROWT;
            end
            S_ROWT:
            begin
                cmd.rowt_rd = 1'b1;
                state_next  = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = stat.place_dbl ? S_WRT : S_DONE;
            end
            S_WRT:
            begin
                cmd.wrt    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.push = stat.out_free;
                if (stat.out_free)
                begin
                    state_next    = clr_pend_reg ? S_CLEAR : S_IDLE;
                    clr_pend_next = 1'b0;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_pend_reg <= clr_pend_next;
        end
    end

endmodule

[hdl/smgr_dpath.sv]
// smgr_dpath: stub lists, adjacency row memory, counters and result register
// depends on smgr_pkg, smgr_stream_if and smgr_ram; commanded by smgr_ctrl
module smgr_dpath #(
    parameter int MAX_VERTICES = 256,
    parameter int MAX_STUBS    = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [smgr_pkg::RATIO_W-1:0]         cfg_wdata,
    smgr_stream_if.sink                          request,
    smgr_stream_if.source                        result,
    input  smgr_pkg::ctrl_cmd_t                  cmd,
    output smgr_pkg::dp_status_t                 stat
);

    localparam int CW    = $clog2(MAX_STUBS + 1);
    localparam int IW    = (MAX_STUBS > 1) ? $clog2(MAX_STUBS) : 1;
    localparam int LW    = IW + 1;
    localparam int LDEP  = 2 ** LW;
    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int LIM_W = smgr_pkg::RATIO_W + CW + 1;
    localparam int VXW   = smgr_pkg::VERTEX_W;
    localparam logic [MAX_VERTICES-1:0] ROW_ONE = {{(MAX_VERTICES-1){1'b0}}, 1'b1};

    smgr_pkg::request_t rq;
    logic               accept;

    logic [smgr_pkg::RATIO_W-1:0] ratio_reg;
    logic [CW-1:0]                sfree_reg, sload_reg, dfree_reg, dload_reg;
    logic [smgr_pkg::FAIL_W-1:0]  fail_reg, fail_next;
    logic                         gave_up_reg;
    logic [VW-1:0]                clr_cnt_reg;
    logic                         dbl_reg;
    logic [IW-1:0]                op_idx_reg, ip_idx_reg, last_idx_reg;
    logic [LIM_W-1:0]             limit_reg;
    logic [VXW-1:0]               s_reg, t_reg, last_out_reg, last_in_reg;
    logic [MAX_VERTICES-1:0]      row_s_reg, row_t_reg;
    logic                         hit_st_reg;
    smgr_pkg::status_t            res_status_reg;
    logic [VXW-1:0]               res_src_reg, res_dst_reg;
    logic                         res_dbl_reg;
    logic                         out_valid_reg;
    smgr_pkg::result_t            out_item_reg;

    logic          is_load, ld_dbl, load_ok, dr_dbl, empty, pick_ok, draw_go;
    logic [CW-1:0] cur_free, cur_loaded, nfree;
    smgr_pkg::status_t quick_status;
    logic          conflict, place, hit_ts, clear_last;

    logic          lst_we;
    logic [LW-1:0] out_waddr, in_waddr, out_raddr, in_raddr;
    logic [VXW-1:0] out_wdata, in_wdata, out_rdata, in_rdata;
    logic          adj_we;
    logic [VW-1:0] adj_waddr, adj_raddr;
    logic [MAX_VERTICES-1:0] adj_wdata, adj_rdata;

    assign rq            = request.data;
    assign request.ready = cmd.in_ready;
    assign accept        = request.valid && cmd.in_ready;

    // accept-time decisions
    always_comb
    begin
        is_load    = (rq.mode == smgr_pkg::MODE_LOAD_SINGLE) ||
                     (rq.mode == smgr_pkg::MODE_LOAD_DOUBLE);
        ld_dbl     = (rq.mode == smgr_pkg::MODE_LOAD_DOUBLE);
        cur_free   = ld_dbl ? dfree_reg : sfree_reg;
        cur_loaded = ld_dbl ? dload_reg : sload_reg;
        load_ok    = (32'(rq.src_vertex) < MAX_VERTICES) &&
                     (32'(rq.dst_vertex) < MAX_VERTICES) &&
                     (32'(cur_free) < MAX_STUBS) && (32'(cur_loaded) < MAX_STUBS);
        dr_dbl     = (sfree_reg == '0);
        nfree      = dr_dbl ? dfree_reg : sfree_reg;
        empty      = (sfree_reg == '0) && (dfree_reg == '0);
        pick_ok    = (rq.out_pick != '0) && (32'(rq.out_pick) <= 32'(nfree)) &&
                     (rq.in_pick != '0) && (32'(rq.in_pick) <= 32'(nfree));
        draw_go    = (rq.mode == smgr_pkg::MODE_DRAW) && !gave_up_reg && !empty && pick_ok;
        case (rq.mode)
            smgr_pkg::MODE_LOAD_SINGLE,
            smgr_pkg::MODE_LOAD_DOUBLE:
                quick_status = load_ok ? smgr_pkg::ST_LOADED : smgr_pkg::ST_BAD_PICK;
            smgr_pkg::MODE_DRAW:
            begin
                if (gave_up_reg)
                    quick_status = smgr_pkg::ST_GAVE_UP;
                else if (empty)
                    quick_status = smgr_pkg::ST_NOTHING_LEFT;
                else
                    quick_status = smgr_pkg::ST_BAD_PICK;
            end
            default:
                quick_status = smgr_pkg::ST_LOADED;
        endcase
    end

    // conflict check on the two adjacency rows
    always_comb
    begin
        hit_ts    = adj_rdata[VW'(s_reg)];
        conflict  = (s_reg == t_reg) || hit_st_reg || hit_ts;
        place     = cmd.check && !conflict;
        fail_next = (fail_reg == smgr_pkg::FAIL_MAX) ? fail_reg
                                                     : fail_reg + smgr_pkg::FAIL_W'(1);
        clear_last = (clr_cnt_reg == VW'(MAX_VERTICES - 1));
    end

    assign stat.in_valid   = request.valid;
    assign stat.draw_go    = draw_go;
    assign stat.restart    = (rq.mode == smgr_pkg::MODE_RESTART);
    assign stat.place_dbl  = !conflict && dbl_reg;
    assign stat.clear_last = clear_last;
    assign stat.out_free   = !out_valid_reg || result.ready;

    // stub list ports
    always_comb
    begin
        lst_we = (accept && is_load && load_ok) || place;
        if (accept)
        begin
            out_waddr = {ld_dbl, IW'(cur_free)};
            in_waddr  = {ld_dbl, IW'(cur_free)};
            out_wdata = rq.src_vertex;
            in_wdata  = rq.dst_vertex;
        end
        else
        begin
            out_waddr = {dbl_reg, op_idx_reg};
            in_waddr  = {dbl_reg, ip_idx_reg};
            out_wdata = last_out_reg;
            in_wdata  = last_in_reg;
        end
        out_raddr = cmd.pick_rd ? {dbl_reg, op_idx_reg} : {dbl_reg, last_idx_reg};
        in_raddr  = cmd.pick_rd ? {dbl_reg, ip_idx_reg} : {dbl_reg, last_idx_reg};
    end

    // adjacency row ports
    always_comb
    begin
        adj_we    = cmd.clear_en || place || cmd.wrt;
        adj_raddr = cmd.last_rd ? VW'(out_rdata) : VW'(t_reg);
        if (cmd.clear_en)
        begin
            adj_waddr = clr_cnt_reg;
            adj_wdata = '0;
        end
        else if (cmd.wrt)
        begin
            adj_waddr = VW'(t_reg);
            adj_wdata = row_t_reg | (ROW_ONE << VW'(s_reg));
        end
        else
        begin
            adj_waddr = VW'(s_reg);
            adj_wdata = row_s_reg | (ROW_ONE << VW'(t_reg));
        end
    end

    smgr_ram #(.WIDTH(VXW), .DEPTH(LDEP)) u_out_list (
        .clk   (clk),
        .we    (lst_we),
        .waddr (out_waddr),
        .wdata (out_wdata),
        .raddr (out_raddr),
        .rdata (out_rdata)
    );

    smgr_ram #(.WIDTH(VXW), .DEPTH(LDEP)) u_in_list (
        .clk   (clk),
        .we    (lst_we),
        .waddr (in_waddr),
        .wdata (in_wdata),
        .raddr (in_raddr),
        .rdata (in_rdata)
    );

    smgr_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj (
        .clk   (clk),
        .we    (adj_we),
        .waddr (adj_waddr),
        .wdata (adj_wdata),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg     <= smgr_pkg::RATIO_RESET;
            sfree_reg     <= '0;
            sload_reg     <= '0;
            dfree_reg     <= '0;
            dload_reg     <= '0;
            fail_reg      <= '0;
            gave_up_reg   <= 1'b0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                ratio_reg <= cfg_wdata;
            end
            if (cmd.clear_en)
            begin
                clr_cnt_reg <= clear_last ? '0 : clr_cnt_reg + VW'(1);
            end
            if (accept && is_load && load_ok)
            begin
                if (ld_dbl)
                begin
                    dfree_reg <= dfree_reg + CW'(1);
                    dload_reg <= dload_reg + CW'(1);
                end
                else
                begin
                    sfree_reg <= sfree_reg + CW'(1);
                    sload_reg <= sload_reg + CW'(1);
                end
            end
            if (accept && (rq.mode == smgr_pkg::MODE_RESTART))
            begin
                sfree_reg   <= '0;
                sload_reg   <= '0;
                dfree_reg   <= '0;
                dload_reg   <= '0;
                fail_reg    <= '0;
                gave_up_reg <= 1'b0;
            end
            if (place)
            begin
                if (dbl_reg)
                begin
                    dfree_reg <= dfree_reg - CW'(1);
                end
                else
                begin
                    sfree_reg <= sfree_reg - CW'(1);
                    if (sfree_reg == CW'(1))
                    begin
                        fail_reg <= '0;
                    end
                end
            end
            else if (cmd.check)
            begin
                fail_reg <= fail_next;
                if (64'(fail_next) > 64'(limit_reg))
                begin
                    gave_up_reg <= 1'b1;
                end
            end
            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // draw pipeline and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_status_reg <= quick_status;
            res_src_reg    <= '0;
            res_dst_reg    <= '0;
            res_dbl_reg    <= 1'b0;
            dbl_reg        <= dr_dbl;
            op_idx_reg     <= IW'(32'(rq.out_pick) - 32'd1);
            ip_idx_reg     <= IW'(32'(rq.in_pick) - 32'd1);
            last_idx_reg   <= IW'(32'(nfree) - 32'd1);
        end
        if (cmd.pick_rd)
        begin
            limit_reg <= LIM_W'(ratio_reg) *
                         (dbl_reg ? LIM_W'({dload_reg, 1'b0}) : LIM_W'(sload_reg));
        end
        if (cmd.last_rd)
        begin
            s_reg <= out_rdata;
            t_reg <= in_rdata;
        end
        if (cmd.rowt_rd)
        begin
            last_out_reg <= out_rdata;
            last_in_reg  <= in_rdata;
            row_s_reg    <= adj_rdata;
            hit_st_reg   <= adj_rdata[VW'(t_reg)];
        end
        if (cmd.check)
        begin
            row_t_reg <= adj_rdata;
            if (!conflict)
            begin
                res_status_reg <= smgr_pkg::ST_PLACED;
                res_src_reg    <= s_reg;
                res_dst_reg    <= t_reg;
                res_dbl_reg    <= dbl_reg;
            end
            else if (64'(fail_next) > 64'(limit_reg))
            begin
                res_status_reg <= smgr_pkg::ST_GAVE_UP;
            end
            else
            begin
                res_status_reg <= smgr_pkg::ST_CONFLICT;
            end
        end
        if (cmd.push)
        begin
            out_item_reg.status         <= res_status_reg;
            out_item_reg.edge_src       <= res_src_reg;
            out_item_reg.edge_dst       <= res_dst_reg;
            out_item_reg.edge_is_double <= res_dbl_reg;
            out_item_reg.single_left    <= smgr_pkg::LEFT_W'(sfree_reg);
            out_item_reg.double_left    <= smgr_pkg::LEFT_W'(dfree_reg);
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_item_reg;

`ifndef SYNTHESIS
    a_single_free_le_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        sfree_reg <= sload_reg)
        else $error("single free count above loaded count");

    a_double_free_le_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        dfree_reg <= dload_reg)
        else $error("double free count above loaded count");

    a_placed_not_loop: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push && (res_status_reg == smgr_pkg::ST_PLACED)) |-> (res_src_reg != res_dst_reg))
        else $error("placed edge is a self edge");

    a_draw_only_when_live: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pick_rd |-> (!gave_up_reg && ((sfree_reg != '0) || (dfree_reg != '0))))
        else $error("draw started after give-up or with nothing free");

    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_en |-> !accept)
        else $error("item accepted during adjacency clearing");
`endif

endmodule

[hdl/stub_matching_graph_randomizer.sv]
// Stub matching graph randomizer. Single and mutual stub pairs are loaded into
// two lists; each draw item picks one free out stub and one free in stub and
// either places the edge or rejects it against an adjacency row memory. Loads,
// restarts and draws answered without memory access are pushed into the result
// register from the done state that follows the accepting idle state. A draw
// that reads the lists steps from the accepting idle state through list read,
// second list read with row s, row t, check and write-back of row s, plus row t
// for a mutual edge, then the result push; the single read port of the row
// memory puts row s and row t in separate steps. The push waits while the result
// register still holds an item that is not taken. After reset and after every
// restart the row memory is cleared one row per cycle, all MAX_VERTICES rows,
// during which no item is accepted.
// depends on smgr_pkg, smgr_stream_if, smgr_ctrl and smgr_dpath
module stub_matching_graph_randomizer #(
    parameter int MAX_VERTICES = 256,
    parameter int MAX_STUBS    = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [smgr_pkg::RATIO_W-1:0]  cfg_wdata,
    smgr_stream_if.sink                   request,
    smgr_stream_if.source                 result
);

    smgr_pkg::ctrl_cmd_t  cmd;
    smgr_pkg::dp_status_t stat;

    smgr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    smgr_dpath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_STUBS    (MAX_STUBS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .request   (request),
        .result    (result),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
